// ----- hw/rtl/vsfx_pkg.sv -----
// ----------------------------------------------------------------------------
// vsfx_pkg: shared definitions of the voice effects mix
// Widths, register indexes, schedule step codes, the quarter-wave sine table
// and small arithmetic helpers used by the controller and the datapath.
// ----------------------------------------------------------------------------
package vsfx_pkg;

	// Word and arithmetic widths.
	localparam int SMP_W  = 16;
	localparam int ST_W   = 24;
	localparam int COEF_W = 17;
	localparam int PH_W   = 32;
	localparam int A_W    = 32;
	localparam int B_W    = 18;
	localparam int P_W    = A_W + B_W;
	localparam int ACC_W  = 45;
	localparam int SUM_W  = COEF_W + 1;

	// Configuration channel.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] CFG_RADIO_W   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_ROBOT_W   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_DOUBLER_W = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_LOW_CUT   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_CUT  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_CARRIER   = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_WOBBLE    = 3'd6;

	// Delay line and sine table sizes.
	localparam int DELAY_DEPTH  = 1024;
	localparam int ADDR_W       = $clog2(DELAY_DEPTH);
	localparam int FILL_W       = ADDR_W + 1;
	localparam int SINE_ENTRIES = 1024;
	localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
	localparam int QTR          = SINE_ENTRIES / 4;
	localparam int QIDX_W       = SINE_BITS - 1;

	// Fixed-point constants.
	localparam logic [COEF_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [PH_W-1:0] CARRIER_RESET = 32'd8500488;
	localparam logic [PH_W-1:0] WOBBLE_RESET  = 32'd71583;
	localparam int ROBOT_DRY_GAIN = 4915 * 32768;
	localparam int ROBOT_WET      = 27853;
	localparam int DOUBLER_BLEND  = 2294;
	localparam int DQ_W           = ADDR_W + 18;
	localparam int DELAY_BASE_Q16 = 576 * 65536;
	localparam int DELAY_MIN_Q16  = 65536;
	localparam longint DELAY_MAX_Q16 = longint'(DELAY_DEPTH - 2) * 65536;

	localparam longint unsigned POLY_A1 = 64'd1686629713;
	localparam longint unsigned POLY_A3 = 64'd693598671;
	localparam longint unsigned POLY_A5 = 64'd85569278;
	localparam longint unsigned POLY_A7 = 64'd5027045;

	// Per-sample schedule steps.
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] S_HP1_MUL  = 5'd0;
	localparam logic [STEP_W-1:0] S_HP1_UPD  = 5'd1;
	localparam logic [STEP_W-1:0] S_H1       = 5'd2;
	localparam logic [STEP_W-1:0] S_HP2_MUL  = 5'd3;
	localparam logic [STEP_W-1:0] S_HP2_UPD  = 5'd4;
	localparam logic [STEP_W-1:0] S_H2       = 5'd5;
	localparam logic [STEP_W-1:0] S_LP1_MUL  = 5'd6;
	localparam logic [STEP_W-1:0] S_LP1_UPD  = 5'd7;
	localparam logic [STEP_W-1:0] S_LP2_MUL  = 5'd8;
	localparam logic [STEP_W-1:0] S_LP2_UPD  = 5'd9;
	localparam logic [STEP_W-1:0] S_RB_MUL1  = 5'd10;
	localparam logic [STEP_W-1:0] S_RB_GAIN  = 5'd11;
	localparam logic [STEP_W-1:0] S_RB_MUL2  = 5'd12;
	localparam logic [STEP_W-1:0] S_RB_OUT   = 5'd13;
	localparam logic [STEP_W-1:0] S_DB_DLY   = 5'd14;
	localparam logic [STEP_W-1:0] S_DB_RDA   = 5'd15;
	localparam logic [STEP_W-1:0] S_DB_RDB   = 5'd16;
	localparam logic [STEP_W-1:0] S_DB_MUL1  = 5'd17;
	localparam logic [STEP_W-1:0] S_DB_DEL   = 5'd18;
	localparam logic [STEP_W-1:0] S_DB_MUL2  = 5'd19;
	localparam logic [STEP_W-1:0] S_DB_OUT   = 5'd20;
	localparam logic [STEP_W-1:0] S_MX_DRY   = 5'd21;
	localparam logic [STEP_W-1:0] S_MX_RADIO = 5'd22;
	localparam logic [STEP_W-1:0] S_MX_ROBOT = 5'd23;
	localparam logic [STEP_W-1:0] S_MX_TINY  = 5'd24;
	localparam logic [STEP_W-1:0] S_MX_SUM   = 5'd25;
	localparam logic [STEP_W-1:0] S_OUT      = 5'd26;

	// Weight normalization: 16 quotient bits per weight.
	localparam int NQ_W = 16;
	localparam int NCNT_W = 5;
	localparam logic [NCNT_W-1:0] NCNT_LOAD  = 5'd0;
	localparam logic [NCNT_W-1:0] NCNT_STORE = 5'd17;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              accept;
		logic              run;
		logic [STEP_W-1:0] step;
		logic              cfg_ready;
		logic              norm_load;
		logic              norm_step;
		logic              norm_store;
		logic              norm_finish;
		logic [1:0]        wsel;
		logic              out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dirty;
		logic out_free;
	} stat_t;

	typedef logic [SMP_W-2:0] qsine_lut_t [QTR+1];

	// One quarter-wave entry: odd polynomial in Q30, rounded to Q15, capped.
	function automatic logic [SMP_W-2:0] qsine_entry(input int j);
		longint unsigned x, x2, t, s;
		x  = longint'(j) << (32 - SINE_BITS);
		x2 = (x * x) >> 30;
		t  = POLY_A5 - ((x2 * POLY_A7) >> 30);
		t  = POLY_A3 - ((x2 * t) >> 30);
		t  = POLY_A1 - ((x2 * t) >> 30);
		s  = (x * t) >> 30;
		s  = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[SMP_W-2:0];
	endfunction

	function automatic qsine_lut_t build_qsine();
		qsine_lut_t lut;
		for (int j = 0; j <= QTR; j++) begin
			lut[j] = qsine_entry(j);
		end
		return lut;
	endfunction

	localparam qsine_lut_t QSINE_LUT = build_qsine();

	// Table sine of a 32-bit phase, Q15 signed.
	function automatic logic signed [SMP_W-1:0] sine_lookup(input logic [PH_W-1:0] phase);
		logic [SINE_BITS-1:0] k;
		logic [QIDX_W-1:0]    idx;
		logic [SMP_W-1:0]     mag;
		k   = phase[PH_W-1 -: SINE_BITS];
		idx = {1'b0, k[SINE_BITS-3:0]};
		if (k[SINE_BITS-2]) begin
			idx = QIDX_W'(QTR) - idx;
		end
		mag = {1'b0, QSINE_LUT[idx]};
		return k[SINE_BITS-1] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic [COEF_W-1:0] clamp_one(input logic [COEF_W-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic logic signed [ST_W-1:0] sat24(input logic signed [35:0] v);
		if (v > 36'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -36'sd8388608) begin
			return 24'sh800000;
		end
		return v[ST_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/vsfx_in_if.sv -----
// ----------------------------------------------------------------------------
// vsfx_in_if: input sample channel
// Valid/ready channel carrying one signed audio sample per word.
// ----------------------------------------------------------------------------
interface vsfx_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [vsfx_pkg::SMP_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// ----- hw/rtl/vsfx_out_if.sv -----
// ----------------------------------------------------------------------------
// vsfx_out_if: output sample channel
// Valid/ready channel carrying one mixed signed audio sample per word.
// ----------------------------------------------------------------------------
interface vsfx_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [vsfx_pkg::SMP_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// ----- hw/rtl/vsfx_cfg_if.sv -----
// ----------------------------------------------------------------------------
// vsfx_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface vsfx_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [vsfx_pkg::CFG_ADDR_W-1:0]     addr;
	logic [vsfx_pkg::CFG_DATA_W-1:0]     wdata;

	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface

// ----- hw/rtl/vsfx_ctrl.sv -----
// ----------------------------------------------------------------------------
// vsfx_ctrl: sequencer of the voice effects mix
// Runs the weight normalization after reset and after weight writes, and
// steps the datapath through the per-sample schedule.
// ----------------------------------------------------------------------------
module vsfx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vsfx_pkg::stat_t   stat,
	output vsfx_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NORM = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0]                      state_q;
	logic [vsfx_pkg::STEP_W-1:0]     step_q;
	logic [vsfx_pkg::NCNT_W-1:0]     ncnt_q;
	logic [1:0]                      wsel_q;

	always_comb begin
		cmd = '0;
		cmd.step = step_q;
		cmd.wsel = wsel_q;
		cmd.cfg_ready = (state_q != ST_NORM);
		in_ready = (state_q == ST_IDLE) && !stat.dirty;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid && !stat.dirty;
			end
			ST_NORM: begin
				if (wsel_q == 2'd3) begin
					cmd.norm_finish = 1'b1;
				end else if (ncnt_q == vsfx_pkg::NCNT_LOAD) begin
					cmd.norm_load = 1'b1;
				end else if (ncnt_q == vsfx_pkg::NCNT_STORE) begin
					cmd.norm_store = 1'b1;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			ST_RUN: begin
				cmd.run = 1'b1;
				cmd.out_load = (step_q == vsfx_pkg::S_OUT) && stat.out_free;
			end
			default: begin
				cmd.cfg_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			ncnt_q <= '0;
			wsel_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (stat.dirty) begin
						state_q <= ST_NORM;
						ncnt_q <= '0;
						wsel_q <= '0;
					end else if (in_valid) begin
						state_q <= ST_RUN;
						step_q <= '0;
					end
				end
				ST_NORM: begin
					if (wsel_q == 2'd3) begin
						state_q <= ST_IDLE;
					end else if (ncnt_q == vsfx_pkg::NCNT_STORE) begin
						ncnt_q <= '0;
						wsel_q <= wsel_q + 2'd1;
					end else begin
						ncnt_q <= ncnt_q + 1'b1;
					end
				end
				ST_RUN: begin
					if (step_q == vsfx_pkg::S_OUT) begin
						if (stat.out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/vsfx_datapath.sv -----
// ----------------------------------------------------------------------------
// vsfx_datapath: arithmetic and storage of the voice effects mix
// Configuration registers, filter and oscillator state, the delay memory,
// one shared multiplier, the weight divider and the output register.
// ----------------------------------------------------------------------------
module vsfx_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vsfx_pkg::cmd_t                      cmd,
	output vsfx_pkg::stat_t                     stat,
	input  logic signed [vsfx_pkg::SMP_W-1:0]   sample_in,
	input  logic                                cfg_valid,
	input  logic [vsfx_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [vsfx_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [vsfx_pkg::SMP_W-1:0]   sample_out
);

	localparam int SMP_W  = vsfx_pkg::SMP_W;
	localparam int ST_W   = vsfx_pkg::ST_W;
	localparam int COEF_W = vsfx_pkg::COEF_W;
	localparam int PH_W   = vsfx_pkg::PH_W;
	localparam int A_W    = vsfx_pkg::A_W;
	localparam int B_W    = vsfx_pkg::B_W;
	localparam int P_W    = vsfx_pkg::P_W;
	localparam int ACC_W  = vsfx_pkg::ACC_W;
	localparam int SUM_W  = vsfx_pkg::SUM_W;
	localparam int ADDR_W = vsfx_pkg::ADDR_W;
	localparam int FILL_W = vsfx_pkg::FILL_W;
	localparam int DQ_W   = vsfx_pkg::DQ_W;
	localparam int NQ_W   = vsfx_pkg::NQ_W;

	// Configuration.
	logic [COEF_W-1:0] w_q [3];
	logic [COEF_W-1:0] lcut_q, hcut_q;
	logic [PH_W-1:0]   cstep_q, wstep_q;
	logic              dirty_q;

	// Normalized weights.
	logic [COEF_W-1:0] nw_q [3];
	logic [COEF_W-1:0] dry_q;
	logic [SUM_W-1:0]  div_r_q;
	logic [NQ_W-1:0]   div_q_q;

	// Per-sample state.
	logic signed [SMP_W-1:0] x_q;
	logic signed [ST_W-1:0]  hp1_q, hp2_q, lp1_q, lp2_q;
	logic [PH_W-1:0]         cph_q, wph_q;
	logic signed [SMP_W-1:0] sc_q, sw_q;
	logic signed [31:0]      t_q;
	logic signed [P_W-1:0]   prod_q;
	logic signed [17:0]      robot_q, tiny_q;
	logic [ADDR_W-1:0]       d_q, wp_q;
	logic [15:0]             frac_q;
	logic                    tap_ok_q;
	logic signed [SMP_W-1:0] a_q;
	logic [FILL_W-1:0]       fill_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SMP_W-1:0] out_q;
	logic                    out_valid_q;

	// Delay memory.
	logic signed [SMP_W-1:0] mem [vsfx_pkg::DELAY_DEPTH];
	logic signed [SMP_W-1:0] rd_q;
	logic [ADDR_W-1:0]       rd_addr;

	logic [COEF_W-1:0] lc, hc;
	logic [COEF_W-1:0] wcl [3];
	logic [SUM_W-1:0]  sum_w;
	logic              need_norm;
	logic [SUM_W:0]    div_r2;
	logic [SUM_W-1:0]  nsum;

	logic signed [A_W-1:0]     mul_a;
	logic signed [B_W-1:0]     mul_b;
	logic signed [P_W-1:0]     prod_rnd;
	logic signed [P_W-17:0]    prod_r16;
	logic signed [P_W-1:0]     prod_rb;
	logic signed [ST_W-1:0]    st_sel;
	logic signed [35:0]        pole_sum;
	logic signed [ST_W-1:0]    pole_new;
	logic signed [DQ_W-1:0]    dq, dq_c;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [ACC_W-17:0]  y_full;
	logic signed [SMP_W-1:0]   y_sat;
	logic                      cfg_fire;

	assign cfg_fire = cfg_valid && cmd.cfg_ready;

	assign lc = vsfx_pkg::clamp_one(lcut_q);
	assign hc = vsfx_pkg::clamp_one(hcut_q);
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wcl[i] = vsfx_pkg::clamp_one(w_q[i]);
		end
	end
	assign sum_w = SUM_W'(wcl[0]) + SUM_W'(wcl[1]) + SUM_W'(wcl[2]);
	assign need_norm = sum_w > SUM_W'(vsfx_pkg::ONE_Q16);
	assign div_r2 = {div_r_q, 1'b0};
	assign nsum = SUM_W'(nw_q[0]) + SUM_W'(nw_q[1]) + SUM_W'(nw_q[2]);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q[0] <= '0;
			w_q[1] <= '0;
			w_q[2] <= '0;
			lcut_q <= vsfx_pkg::ONE_Q16;
			hcut_q <= vsfx_pkg::ONE_Q16;
			cstep_q <= vsfx_pkg::CARRIER_RESET;
			wstep_q <= vsfx_pkg::WOBBLE_RESET;
			dirty_q <= 1'b1;
		end else begin
			if (cmd.norm_load && cmd.wsel == 2'd0) begin
				dirty_q <= 1'b0;
			end
			if (cfg_fire) begin
				case (cfg_addr)
					vsfx_pkg::CFG_RADIO_W: begin
						w_q[0] <= cfg_wdata[COEF_W-1:0];
						dirty_q <= 1'b1;
					end
					vsfx_pkg::CFG_ROBOT_W: begin
						w_q[1] <= cfg_wdata[COEF_W-1:0];
						dirty_q <= 1'b1;
					end
					vsfx_pkg::CFG_DOUBLER_W: begin
						w_q[2] <= cfg_wdata[COEF_W-1:0];
						dirty_q <= 1'b1;
					end
					vsfx_pkg::CFG_LOW_CUT: begin
						lcut_q <= cfg_wdata[COEF_W-1:0];
					end
					vsfx_pkg::CFG_HIGH_CUT: begin
						hcut_q <= cfg_wdata[COEF_W-1:0];
					end
					vsfx_pkg::CFG_CARRIER: begin
						cstep_q <= cfg_wdata[PH_W-1:0];
					end
					vsfx_pkg::CFG_WOBBLE: begin
						wstep_q <= cfg_wdata[PH_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Restoring divider for w * 65536 / sum, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (cmd.norm_load) begin
			div_r_q <= SUM_W'(wcl[cmd.wsel]);
			div_q_q <= '0;
		end else if (cmd.norm_step) begin
			if (div_r2 >= {1'b0, sum_w}) begin
				div_r_q <= SUM_W'(div_r2 - {1'b0, sum_w});
				div_q_q <= {div_q_q[NQ_W-2:0], 1'b1};
			end else begin
				div_r_q <= div_r2[SUM_W-1:0];
				div_q_q <= {div_q_q[NQ_W-2:0], 1'b0};
			end
		end
		if (cmd.norm_store) begin
			nw_q[cmd.wsel] <= need_norm ? COEF_W'(div_q_q) : wcl[cmd.wsel];
		end
		if (cmd.norm_finish) begin
			dry_q <= (nsum < SUM_W'(vsfx_pkg::ONE_Q16)) ?
				COEF_W'(SUM_W'(vsfx_pkg::ONE_Q16) - nsum) : '0;
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			vsfx_pkg::S_HP1_MUL: begin
				mul_a = A_W'(x_q) - A_W'(hp1_q);
				mul_b = $signed({1'b0, lc});
			end
			vsfx_pkg::S_HP2_MUL: begin
				mul_a = t_q - A_W'(hp2_q);
				mul_b = $signed({1'b0, lc});
			end
			vsfx_pkg::S_LP1_MUL: begin
				mul_a = t_q - A_W'(lp1_q);
				mul_b = $signed({1'b0, hc});
			end
			vsfx_pkg::S_LP2_MUL: begin
				mul_a = A_W'(lp1_q) - A_W'(lp2_q);
				mul_b = $signed({1'b0, hc});
			end
			vsfx_pkg::S_RB_MUL1: begin
				mul_a = A_W'(sc_q);
				mul_b = B_W'(vsfx_pkg::ROBOT_WET);
			end
			vsfx_pkg::S_RB_MUL2: begin
				mul_a = t_q;
				mul_b = B_W'(x_q);
			end
			vsfx_pkg::S_DB_MUL1: begin
				mul_a = A_W'(rd_q) - A_W'(a_q);
				mul_b = $signed({2'b00, frac_q});
			end
			vsfx_pkg::S_DB_MUL2: begin
				mul_a = t_q - A_W'(x_q);
				mul_b = B_W'(vsfx_pkg::DOUBLER_BLEND);
			end
			vsfx_pkg::S_MX_DRY: begin
				mul_a = A_W'(x_q);
				mul_b = $signed({1'b0, dry_q});
			end
			vsfx_pkg::S_MX_RADIO: begin
				mul_a = A_W'(lp2_q);
				mul_b = $signed({1'b0, nw_q[0]});
			end
			vsfx_pkg::S_MX_ROBOT: begin
				mul_a = A_W'(robot_q);
				mul_b = $signed({1'b0, nw_q[1]});
			end
			vsfx_pkg::S_MX_TINY: begin
				mul_a = A_W'(tiny_q);
				mul_b = $signed({1'b0, nw_q[2]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Product rounded half up and floored by 2^16, and by 2^30 for the ring.
	assign prod_rnd = prod_q + P_W'(32768);
	assign prod_r16 = prod_rnd[P_W-1:16];
	assign prod_rb = prod_q + P_W'(2 ** 29);

	always_comb begin
		case (cmd.step)
			vsfx_pkg::S_HP1_UPD: st_sel = hp1_q;
			vsfx_pkg::S_HP2_UPD: st_sel = hp2_q;
			vsfx_pkg::S_LP1_UPD: st_sel = lp1_q;
			default: st_sel = lp2_q;
		endcase
	end
	assign pole_sum = 36'(st_sel) + 36'(prod_r16);
	assign pole_new = vsfx_pkg::sat24(pole_sum);

	// Wobbled delay in Q16, clamped to the usable taps.
	always_comb begin
		dq = DQ_W'(vsfx_pkg::DELAY_BASE_Q16) + (DQ_W'(sw_q) <<< 7) + (DQ_W'(sw_q) <<< 4);
		dq_c = dq;
		if (dq < DQ_W'(vsfx_pkg::DELAY_MIN_Q16)) begin
			dq_c = DQ_W'(vsfx_pkg::DELAY_MIN_Q16);
		end else if (dq > DQ_W'(vsfx_pkg::DELAY_MAX_Q16)) begin
			dq_c = DQ_W'(vsfx_pkg::DELAY_MAX_Q16);
		end
	end

	assign rd_addr = (cmd.step == vsfx_pkg::S_DB_RDA) ? (wp_q - d_q) : (wp_q - d_q - 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.run && cmd.step == vsfx_pkg::S_HP1_MUL) begin
			mem[wp_q] <= x_q;
		end
		rd_q <= mem[rd_addr];
	end

	// Output rounding and saturation.
	assign acc_rnd = acc_q + ACC_W'(32768);
	assign y_full = acc_rnd[ACC_W-1:16];
	always_comb begin
		if (y_full > (ACC_W-16)'(32767)) begin
			y_sat = 16'sh7FFF;
		end else if (y_full < -(ACC_W-16)'(32768)) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = y_full[SMP_W-1:0];
		end
	end

	// Sample schedule, payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q <= sample_in;
		end
		if (cmd.run) begin
			prod_q <= mul_a * mul_b;
			case (cmd.step)
				vsfx_pkg::S_HP1_MUL: begin
					sc_q <= vsfx_pkg::sine_lookup(cph_q);
					sw_q <= vsfx_pkg::sine_lookup(wph_q);
				end
				vsfx_pkg::S_H1: t_q <= 32'(x_q) - 32'(hp1_q);
				vsfx_pkg::S_H2: t_q <= t_q - 32'(hp2_q);
				vsfx_pkg::S_RB_GAIN: t_q <= 32'(vsfx_pkg::ROBOT_DRY_GAIN) + prod_q[31:0];
				vsfx_pkg::S_RB_OUT: robot_q <= $signed(prod_rb[47:30]);
				vsfx_pkg::S_DB_DLY: begin
					d_q <= dq_c[16 +: ADDR_W];
					frac_q <= dq_c[15:0];
				end
				vsfx_pkg::S_DB_RDB: a_q <= rd_q;
				vsfx_pkg::S_DB_DEL: t_q <= tap_ok_q ? (32'(a_q) + 32'(prod_r16)) : '0;
				vsfx_pkg::S_DB_OUT: tiny_q <= 18'(x_q) + $signed(prod_r16[17:0]);
				vsfx_pkg::S_MX_RADIO: acc_q <= prod_q[ACC_W-1:0];
				vsfx_pkg::S_MX_ROBOT: acc_q <= acc_q + prod_q[ACC_W-1:0];
				vsfx_pkg::S_MX_TINY: acc_q <= acc_q + prod_q[ACC_W-1:0];
				vsfx_pkg::S_MX_SUM: acc_q <= acc_q + prod_q[ACC_W-1:0];
				default: begin
				end
			endcase
		end
		if (cmd.out_load) begin
			out_q <= y_sat;
		end
	end

	// Sample schedule, state that reset clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp1_q <= '0;
			hp2_q <= '0;
			lp1_q <= '0;
			lp2_q <= '0;
			cph_q <= '0;
			wph_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
			tap_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.run) begin
				case (cmd.step)
					vsfx_pkg::S_HP1_MUL: begin
						cph_q <= cph_q + cstep_q;
						wph_q <= wph_q + wstep_q;
					end
					vsfx_pkg::S_HP1_UPD: hp1_q <= pole_new;
					vsfx_pkg::S_HP2_UPD: hp2_q <= pole_new;
					vsfx_pkg::S_LP1_UPD: lp1_q <= pole_new;
					vsfx_pkg::S_LP2_UPD: lp2_q <= pole_new;
					vsfx_pkg::S_DB_DLY: tap_ok_q <= fill_q > FILL_W'(dq_c[16 +: ADDR_W]);
					vsfx_pkg::S_DB_OUT: begin
						wp_q <= wp_q + 1'b1;
						if (fill_q < FILL_W'(vsfx_pkg::DELAY_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.dirty = dirty_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;

endmodule

// ----- hw/rtl/voice_special_effects_mix_core.sv -----
// ----------------------------------------------------------------------------
// voice_special_effects_mix_core: radio, robot and doubler voice effects mix
// Top level joining the sequencer and the datapath to the sample channels and
// the configuration channel.
// ----------------------------------------------------------------------------
// Each input word is one signed Q1.15 sample. It feeds a radio band-pass (two
// one-pole high-pass and two one-pole low-pass stages), a ring modulator with
// a sine carrier and 15% dry, and a doubler with a wobbling fractional delay
// of about 576 samples blended at 3.5%; the three are mixed with the dry
// sample by the three weights and the sum saturates to 16 bits. One output
// word comes out for every input word, in order. From acceptance a sample
// steps through the schedule to its output register: the datapath has a single
// 32 by 18 bit multiplier, and the 27-step schedule that shares it runs one
// sample at a time. The next sample is accepted in the cycle after the result
// is loaded, while that result may still wait for the output ready. After
// reset and after any write of a mix weight the block scales the weights
// (one quotient bit per cycle for each of three weights), and accepts no
// sample in that time; the configuration channel holds ready low during this
// pass. Configuration should be written only while no sample is in flight.
// ----------------------------------------------------------------------------
module voice_special_effects_mix_core (
	input  logic             clk,
	input  logic             arst_n,
	vsfx_in_if.sink          din,
	vsfx_out_if.source       dout,
	vsfx_cfg_if.sink         cfg
);

	vsfx_pkg::cmd_t  cmd;
	vsfx_pkg::stat_t stat;

	// The sequencer decides when a word is taken and which step runs.
	vsfx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds all arithmetic, state and the delay memory.
	vsfx_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sample_in  (din.sample_in),
		.cfg_valid  (cfg.valid),
		.cfg_addr   (cfg.addr),
		.cfg_wdata  (cfg.wdata),
		.out_valid  (dout.valid),
		.out_ready  (dout.ready),
		.sample_out (dout.sample_out)
	);

	// Configuration is refused only during the weight scaling pass.
	assign cfg.ready = cmd.cfg_ready;

endmodule

// ----- tb/tb_voice_special_effects_mix_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voice_special_effects_mix_core: self-checking bench of the voice mix
// Drives samples with random gaps and register writes, predicts each mixed
// output word from a local model of the three effects, and compares in order.
// ----------------------------------------------------------------------------
module tb_voice_special_effects_mix_core;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DEPTH = vsfx_pkg::DELAY_DEPTH;

	logic clk;
	logic arst_n;

	vsfx_in_if  din ();
	vsfx_out_if dout ();
	vsfx_cfg_if cfg ();

	voice_special_effects_mix_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cfg    (cfg)
	);

	// Register copies kept by the predictor.
	logic [16:0] mix_radio, mix_robot, mix_doubler, hp_coef, lp_coef;
	logic [31:0] carrier_inc, wobble_inc;

	// Effect state mirrored from the block's behavior.
	longint      hp1, hp2, lp1, lp2;
	logic [31:0] carrier_ph, wobble_ph;
	logic signed [15:0] echo_line [DEPTH];
	int          echo_fill;
	int          echo_wr;

	logic signed [15:0] mixed_expected [$];
	int  fail_count;
	int  idle_cycles;
	bit  sink_stall_free;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor division by a power of two; >>> on a longint is arithmetic.
	function automatic longint floor_sh(input longint v, input int sh);
		return v >>> sh;
	endfunction

	// Sine table value of a phase, built from the same quarter-wave polynomial.
	function automatic longint wave_q15(input logic [31:0] phase);
		longint unsigned k, p, x, x2, t, s;
		int quad;
		k = phase >> (32 - vsfx_pkg::SINE_BITS);
		p = (k << 32) / vsfx_pkg::SINE_ENTRIES;
		quad = int'(p >> 30) & 3;
		x = p & 64'h3FFF_FFFF;
		if (quad[0]) begin
			x = (64'd1 << 30) - x;
		end
		x2 = (x * x) >> 30;
		t = 64'd85569278 - ((x2 * 64'd5027045) >> 30);
		t = 64'd693598671 - ((x2 * t) >> 30);
		t = 64'd1686629713 - ((x2 * t) >> 30);
		s = (x * t) >> 30;
		s = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return quad >= 2 ? -longint'(s) : longint'(s);
	endfunction

	function automatic longint clip24(input longint v);
		if (v > 8388607) begin
			return 8388607;
		end
		if (v < -8388608) begin
			return -8388608;
		end
		return v;
	endfunction

	function automatic longint pole(input longint st, input longint in_v,
			input logic [16:0] c);
		return clip24(st + floor_sh((in_v - st) * longint'(c) + 32768, 16));
	endfunction

	function automatic longint unity_clip(input logic [16:0] v);
		return v > 17'd65536 ? 65536 : longint'(v);
	endfunction

	// Works out the mixed output of one sample and advances the effect state.
	task automatic mix_predict(input logic signed [15:0] smp);
		longint x, lc, hc, h1, h2, radio, robot, gain, tiny, dq, delayed;
		longint a, b, wr, wb, wt, total, dry, acc, y;
		int d, frac, wp;
		x = longint'(smp);
		lc = unity_clip(hp_coef);
		hc = unity_clip(lp_coef);
		hp1 = pole(hp1, x, lc[16:0]);
		h1 = x - hp1;
		hp2 = pole(hp2, h1, lc[16:0]);
		h2 = h1 - hp2;
		lp1 = pole(lp1, h2, hc[16:0]);
		lp2 = pole(lp2, lp1, hc[16:0]);
		radio = lp2;

		gain = 64'sd4915 * 32768 + 64'sd27853 * wave_q15(carrier_ph);
		carrier_ph += carrier_inc;
		robot = floor_sh(x * gain + (64'sd1 <<< 29), 30);

		// Doubler: tap pair behind the newest slot, zero until the line holds more samples than the tap delay.
		wp = echo_wr;
		echo_line[wp] = smp;
		dq = 64'sd37748736 + 144 * wave_q15(wobble_ph);
		if (dq < 65536) begin
			dq = 65536;
		end
		if (dq > longint'(DEPTH - 2) * 65536) begin
			dq = longint'(DEPTH - 2) * 65536;
		end
		d = int'(dq >>> 16);
		frac = int'(dq & 64'hFFFF);
		delayed = 0;
		if (echo_fill > d) begin
			a = echo_line[(wp + DEPTH - d) % DEPTH];
			b = echo_line[(wp + 2 * DEPTH - d - 1) % DEPTH];
			delayed = a + floor_sh((b - a) * frac + 32768, 16);
		end
		wobble_ph += wobble_inc;
		echo_wr = (echo_wr + 1) % DEPTH;
		if (echo_fill < DEPTH) begin
			echo_fill++;
		end
		tiny = x + floor_sh((delayed - x) * 2294 + 32768, 16);

		wr = unity_clip(mix_radio);
		wb = unity_clip(mix_robot);
		wt = unity_clip(mix_doubler);
		total = wr + wb + wt;
		if (total > 65536) begin
			wr = wr * 65536 / total;
			wb = wb * 65536 / total;
			wt = wt * 65536 / total;
		end
		total = wr + wb + wt;
		dry = total < 65536 ? 65536 - total : 0;
		acc = x * dry + radio * wr + robot * wb + tiny * wt;
		y = floor_sh(acc + 32768, 16);
		if (y > 32767) begin
			y = 32767;
		end
		if (y < -32768) begin
			y = -32768;
		end
		mixed_expected.push_back(16'(y));
	endtask

	// Sends one sample after a random gap and records its expected output.
	// Valid stays high after the handshake so that a following word can go
	// back to back; whoever stops sending drops it.
	task automatic send_sample(input logic signed [15:0] smp);
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0) begin
			gap = 0;
		end
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din.valid <= 1'b1;
		din.sample_in <= smp;
		@(posedge clk);
		while (!din.ready) begin
			@(posedge clk);
		end
		mix_predict(smp);
	endtask

	// Waits for all outputs, then lets the block settle before a register write.
	task automatic drain_outputs();
		din.valid <= 1'b0;
		while (mixed_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [vsfx_pkg::CFG_ADDR_W-1:0] idx,
			input logic [31:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.wdata <= val;
		@(posedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
		end
		cfg.valid <= 1'b0;
		case (idx)
			vsfx_pkg::CFG_RADIO_W:   mix_radio = val[16:0];
			vsfx_pkg::CFG_ROBOT_W:   mix_robot = val[16:0];
			vsfx_pkg::CFG_DOUBLER_W: mix_doubler = val[16:0];
			vsfx_pkg::CFG_LOW_CUT:   hp_coef = val[16:0];
			vsfx_pkg::CFG_HIGH_CUT:  lp_coef = val[16:0];
			vsfx_pkg::CFG_CARRIER:   carrier_inc = val;
			vsfx_pkg::CFG_WOBBLE:    wobble_inc = val;
			default: ;
		endcase
	endtask

	function automatic logic signed [15:0] any_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 255)) - 16'sd128;
			default: return 16'($urandom);
		endcase
	endfunction

	// Extremes of the sample, reset settings: dry path only.
	task automatic test_directed_extremes();
		logic signed [15:0] picks [10];
		picks = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
			16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh8000, 16'sh1234};
		foreach (picks[i]) begin
			send_sample(picks[i]);
		end
		drain_outputs();
	endtask

	// Each effect alone at full weight, then weights above one that need scaling.
	task automatic test_directed_effects();
		write_reg(vsfx_pkg::CFG_RADIO_W, 32'd65536);
		write_reg(vsfx_pkg::CFG_LOW_CUT, 32'd3000);
		write_reg(vsfx_pkg::CFG_HIGH_CUT, 32'd20000);
		repeat (4) send_sample(any_sample());
		drain_outputs();
		write_reg(vsfx_pkg::CFG_RADIO_W, 32'd0);
		write_reg(vsfx_pkg::CFG_ROBOT_W, 32'h1FFFF);
		write_reg(vsfx_pkg::CFG_CARRIER, 32'hFFFF_FFFF);
		repeat (4) send_sample(any_sample());
		drain_outputs();
		write_reg(vsfx_pkg::CFG_ROBOT_W, 32'd0);
		write_reg(vsfx_pkg::CFG_DOUBLER_W, 32'd65536);
		write_reg(vsfx_pkg::CFG_WOBBLE, 32'h4000_0000);
		repeat (4) send_sample(any_sample());
		drain_outputs();
		write_reg(vsfx_pkg::CFG_RADIO_W, 32'h1FFFF);
		write_reg(vsfx_pkg::CFG_ROBOT_W, 32'd40000);
		write_reg(7, 32'hDEAD_BEEF);
		repeat (3) send_sample(any_sample());
		drain_outputs();
	endtask

	// Random phases: new register settings, then a burst of random samples;
	// over the phases the delay line fills so the doubler taps come alive.
	task automatic test_random_phases();
		logic [vsfx_pkg::CFG_ADDR_W-1:0] idx;
		logic [31:0] val;
		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < 7; r++) begin
				idx = r[vsfx_pkg::CFG_ADDR_W-1:0];
				if (r < 5) begin
					case ($urandom_range(0, 3))
						0: val = 32'd0;
						1: val = 32'd65536;
						2: val = 32'h1FFFF;
						default: val = $urandom_range(0, 70000);
					endcase
				end else begin
					val = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000);
				end
				write_reg(idx, val);
			end
			for (int n = 0; n < 240; n++) begin
				send_sample(any_sample());
				if (ph == 2 && n == 120) begin
					// Hold the source until every output word has come back.
					din.valid <= 1'b0;
					while (mixed_expected.size() != 0) begin
						@(posedge clk);
					end
				end
			end
			drain_outputs();
		end
	endtask

	// Output side: random stall per word, and checks against the oldest prediction.
	initial begin
		int stall;
		dout.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_stall_free ? 0 : $urandom_range(0, 16);
			if ($urandom_range(0, 3) == 0) begin
				stall = 0;
			end
			if (stall > 0) begin
				dout.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout.ready <= 1'b1;
			@(posedge clk);
			while (!dout.valid) begin
				@(posedge clk);
			end
			if (mixed_expected.size() == 0) begin
				$error("sample_out: unexpected word %0d", dout.sample_out);
				fail_count++;
			end else begin
				if (dout.sample_out !== mixed_expected[0]) begin
					$error("sample_out: expected %0d actual %0d",
						mixed_expected[0], dout.sample_out);
					fail_count++;
				end
				void'(mixed_expected.pop_front());
			end
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((din.valid && din.ready) || (dout.valid && dout.ready) ||
				(cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		sink_stall_free = 1'b0;
		arst_n = 1'b0;
		din.valid = 1'b0;
		din.sample_in = '0;
		cfg.valid = 1'b0;
		cfg.addr = '0;
		cfg.wdata = '0;
		mix_radio = '0;
		mix_robot = '0;
		mix_doubler = '0;
		hp_coef = 17'd65536;
		lp_coef = 17'd65536;
		carrier_inc = vsfx_pkg::CARRIER_RESET;
		wobble_inc = vsfx_pkg::WOBBLE_RESET;
		hp1 = 0;
		hp2 = 0;
		lp1 = 0;
		lp2 = 0;
		carrier_ph = '0;
		wobble_ph = '0;
		echo_fill = 0;
		echo_wr = 0;
		foreach (echo_line[i]) begin
			echo_line[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_directed_effects();
		test_random_phases();

		sink_stall_free = 1'b1;
		drain_outputs();
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
